// ===== rtl/core/bra_pkg.sv =====
// Package for the bitmap run allocator: beat payload types, codes and
// the command and status structs between controller and datapath.
// No dependencies; every other file in rtl/core imports this package.
package bra_pkg;

  // Pool size defaults and fixed field widths.
  localparam int TOTAL_BLOCKS_DEF = 64;
  localparam int MAX_USABLE       = 64;
  localparam int CNT_W            = 7;
  localparam int POS_W            = 6;
  localparam int ST_W             = 2;
  localparam logic [CNT_W-1:0] USABLE_RESET = 7'd64;

  // Item commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

  // Datapath operation codes.
  localparam logic [3:0] OP_NONE       = 4'd0;
  localparam logic [3:0] OP_LOAD       = 4'd1;
  localparam logic [3:0] OP_INIT_ALLOC = 4'd2;
  localparam logic [3:0] OP_INIT_FREE  = 4'd3;
  localparam logic [3:0] OP_SCAN       = 4'd4;
  localparam logic [3:0] OP_PASS2      = 4'd5;
  localparam logic [3:0] OP_FOUND      = 4'd6;
  localparam logic [3:0] OP_SET        = 4'd7;
  localparam logic [3:0] OP_CHK        = 4'd8;
  localparam logic [3:0] OP_REWIND     = 4'd9;
  localparam logic [3:0] OP_CLR        = 4'd10;

  typedef struct packed {
    logic             command;
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] start_block;
    logic [ST_W-1:0]  status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic [3:0]      op;
    logic            res_we;
    logic [ST_W-1:0] res_status;
    logic            out_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clearing;
    logic count_zero;
    logic is_free;
    logic free_oob;
    logic scan_end;
    logic pass2;
    logic bit_occ;
    logic run_hit;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/bra_dpath.sv =====
// Datapath of the bitmap run allocator: occupancy bitmap, cursor, walk
// counters, config register and output register. Depends on bra_pkg.
// Executes one operation per cycle as commanded by bra_ctrl.
module bra_dpath #(
  parameter int MAP_BITS = bra_pkg::MAX_USABLE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bra_pkg::ctl_cmd_t            cmd,
  output bra_pkg::dp_stat_t            stat,
  input  bra_pkg::in_item_t            in_data,
  input  logic                         cfg_write_en,
  input  logic [bra_pkg::CNT_W-1:0]    cfg_write_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bra_pkg::out_item_t           out_data
);
  import bra_pkg::*;

  localparam int IDX_W = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
  localparam logic [CNT_W-1:0] MAP_SIZE = CNT_W'(MAP_BITS);

  logic                map_mem [MAP_BITS];
  logic [CNT_W-1:0]    usable;
  logic [CNT_W-1:0]    cursor;
  in_item_t            item;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    run;
  logic [CNT_W-1:0]    left;
  logic [CNT_W-1:0]    start;
  logic                pass2;
  logic [ST_W-1:0]     res_status;
  logic [POS_W-1:0]    res_start;
  logic                clearing;
  logic [IDX_W-1:0]    clr_idx;
  logic                bit_now;

  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] lim2;
  logic [CNT_W-1:0] scan_limit;
  logic [CNT_W-1:0] start_next;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W:0]   free_end;
  logic             map_we;
  logic [IDX_W-1:0] map_waddr;
  logic             map_wdata;

  // Effective pool size and the bound of the current scan pass.
  assign size       = (usable > MAP_SIZE) ? MAP_SIZE : usable;
  assign lim2       = (cursor < size) ? cursor : size;
  assign scan_limit = pass2 ? lim2 : size;
  assign free_end   = (CNT_W+1)'(item.position) + (CNT_W+1)'(item.count);
  assign start_next = idx + CNT_W'(1) - item.count;

  // Walk index for the next cycle; the bitmap is read at it, so the registered bit matches the walk index.
  always_comb begin
    idx_next = idx;
    case (cmd.op)
      OP_INIT_ALLOC: begin
        idx_next = cursor;
      end
      OP_INIT_FREE, OP_REWIND: begin
        idx_next = CNT_W'(item.position);
      end
      OP_SCAN, OP_SET, OP_CHK, OP_CLR: begin
        idx_next = idx + CNT_W'(1);
      end
      OP_PASS2: begin
        idx_next = '0;
      end
      OP_FOUND: begin
        idx_next = start_next;
      end
      default: begin
      end
    endcase
  end

  // Single bitmap write port: the clearing pass after reset, then marks and clears.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = idx[IDX_W-1:0];
    map_wdata = 1'b0;
    if (clearing) begin
      map_we    = 1'b1;
      map_waddr = clr_idx;
    end else if (cmd.op == OP_SET) begin
      map_we    = 1'b1;
      map_wdata = 1'b1;
    end else if (cmd.op == OP_CLR) begin
      map_we = 1'b1;
    end
  end

  // Bitmap storage with a registered read of the block at the walk index.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    bit_now <= (idx_next < MAP_SIZE) ? map_mem[idx_next[IDX_W-1:0]] : 1'b0;
  end

  // Status back to the controller.
  always_comb begin
    stat.clearing   = clearing;
    stat.count_zero = (item.count == '0);
    stat.is_free    = (item.command == CMD_FREE);
    stat.free_oob   = (free_end > (CNT_W+1)'(size));
    stat.scan_end   = (idx >= scan_limit);
    stat.pass2      = pass2;
    stat.bit_occ    = bit_now;
    stat.run_hit    = !bit_now && ((run + CNT_W'(1)) == item.count);
    stat.last       = (left == CNT_W'(1));
    stat.out_free   = !out_valid || !out_stall;
  end

  // Clearing pass, cursor, config register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      cursor    <= '0;
      usable    <= USABLE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(MAP_BITS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (cfg_write_en) begin
        usable <= cfg_write_data;
      end
      case (cmd.op)
        OP_SET: begin
          if (left == CNT_W'(1)) begin
            cursor <= start + item.count;
          end
        end
        OP_CLR: begin
          if (left == CNT_W'(1)) begin
            cursor <= CNT_W'(item.position);
          end
        end
        default: begin
        end
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch, walk counters and result registers.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    case (cmd.op)
      OP_LOAD: begin
        item <= in_data;
      end
      OP_INIT_ALLOC: begin
        run   <= '0;
        pass2 <= 1'b0;
      end
      OP_INIT_FREE: begin
        left <= item.count;
      end
      OP_SCAN: begin
        run <= bit_now ? '0 : run + CNT_W'(1);
      end
      OP_PASS2: begin
        run   <= '0;
        pass2 <= 1'b1;
      end
      OP_FOUND: begin
        start <= start_next;
        left  <= item.count;
      end
      OP_SET, OP_CHK, OP_CLR: begin
        left <= left - CNT_W'(1);
      end
      OP_REWIND: begin
        left <= item.count;
      end
      default: begin
      end
    endcase
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_start  <= (cmd.res_status == ST_OK && item.command == CMD_ALLOC) ?
                    start[POS_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_data.start_block <= res_start;
      out_data.status      <= res_status;
    end
  end

  // A run is only marked over free blocks and only cleared over occupied ones.
  a_set_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SET |-> !bit_now)
    else $error("allocation marks a block that is already occupied");

  a_clr_occ: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_CLR |-> bit_now)
    else $error("free clears a block that is not occupied");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= MAP_SIZE)
    else $error("search cursor beyond the bitmap");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.start_block == '0)
    else $error("failed result carries a nonzero start block");

endmodule

// ===== rtl/core/bra_ctrl.sv =====
// Controller of the bitmap run allocator: sequences the search, mark,
// check and clear walks of bra_dpath one block per cycle. Depends on bra_pkg.
module bra_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bra_pkg::dp_stat_t stat,
  output bra_pkg::ctl_cmd_t cmd
);
  import bra_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SET    = 3'd3;
  localparam logic [2:0] S_FCHK   = 3'd4;
  localparam logic [2:0] S_FCLR   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Input beats wait while an item is in progress or the bitmap is being cleared.
  assign in_stall = (state != S_IDLE) || stat.clearing;

  // Next state and datapath command.
  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.res_we     = 1'b0;
    cmd.res_status = ST_OK;
    cmd.out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && !stat.clearing) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.count_zero || (stat.is_free && stat.free_oob)) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FINISH;
        end else if (stat.is_free) begin
          cmd.op     = OP_INIT_FREE;
          state_next = S_FCHK;
        end else begin
          cmd.op     = OP_INIT_ALLOC;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          if (!stat.pass2) begin
            cmd.op = OP_PASS2;
          end else begin
            cmd.res_we     = 1'b1;
            cmd.res_status = ST_NOSPACE;
            state_next     = S_FINISH;
          end
        end else if (stat.run_hit) begin
          cmd.op     = OP_FOUND;
          state_next = S_SET;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_SET: begin
        cmd.op = OP_SET;
        if (stat.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_FINISH;
        end
      end
      S_FCHK: begin
        if (!stat.bit_occ) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_BAD;
          state_next     = S_FINISH;
        end else if (stat.last) begin
          cmd.op     = OP_REWIND;
          state_next = S_FCLR;
        end else begin
          cmd.op = OP_CHK;
        end
      end
      S_FCLR: begin
        cmd.op = OP_CLR;
        if (stat.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is written only on entering finish, and loaded out only from finish.
  a_res_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.res_we |=> state == S_FINISH)
    else $error("result written without entering finish");

  a_load_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> state == S_FINISH && stat.out_free)
    else $error("output loaded outside finish or while occupied");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_CHECK)
    else $error("accepted beat did not start a check");

endmodule

// ===== rtl/core/bitmap_run_allocator.sv =====
// Bitmap run allocator, top level: next-fit allocation and free of block runs.
// Allocate scans from the cursor to the usable end, wraps once to block 0 if needed,
// then marks the found run; free checks every block of the range and then clears it;
// a zero count or a free range past the usable end is reported bad without a walk.
// One item at a time; a stalled output holds the result in finish.
// Sync reset: cursor 0, usable_blocks 64, output empty, then a bitmap clear pass.
module bitmap_run_allocator #(
  parameter int TOTAL_BLOCKS = bra_pkg::TOTAL_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bra_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bra_pkg::out_item_t        out_data,
  input  logic                      cfg_write_en,
  input  logic [bra_pkg::CNT_W-1:0] cfg_write_data
);
  import bra_pkg::*;

  // Only the first MAX_USABLE blocks can ever be addressed.
  localparam int MAP_BITS = (TOTAL_BLOCKS < MAX_USABLE) ? TOTAL_BLOCKS : MAX_USABLE;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bra_dpath #(
    .MAP_BITS (MAP_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_data        (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule

// ===== dv/bitmap_run_allocator_tb.sv =====
// Self-checking testbench for bitmap_run_allocator: directed corner items, then random
// allocate and free traffic under several pool sizes, checked against a tracked copy of the pool.
// Depends on bra_pkg and the bitmap_run_allocator RTL.
module bitmap_run_allocator_tb;
  import bra_pkg::*;

  localparam int POOL_BLOCKS    = TOTAL_BLOCKS_DEF;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;

  // Pool tracker: predicts each reply from its own copy of the bitmap and cursor,
  // and holds the replies still owed by the block.
  class alloc_checker;
    logic [POOL_BLOCKS-1:0] occupied;
    int cursor;
    int usable;
    out_item_t reply_q[$];
    int mismatches;

    function new();
      occupied   = '0;
      cursor     = 0;
      usable     = int'(USABLE_RESET);
      mismatches = 0;
    endfunction

    function void set_usable(int v);
      usable = v;
    endfunction

    function int pool_size();
      return (usable > POOL_BLOCKS) ? POOL_BLOCKS : usable;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s", msg);
      end
    endfunction

    // Lowest-ending run of n free blocks within [from, upto).
    function bit find_run(int from, int upto, int n, output int first);
      int run;
      run = 0;
      for (int i = from; i < upto; i++) begin
        if (occupied[i]) begin
          run = 0;
        end else begin
          run++;
          if (run == n) begin
            first = i + 1 - n;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function out_item_t predict_reply(in_item_t it);
      out_item_t r;
      int size, cnt, pos, first, lim2;
      bit found;
      size  = pool_size();
      cnt   = int'(it.count);
      pos   = int'(it.position);
      first = 0;
      found = 1'b0;
      r.start_block = '0;
      if (cnt == 0) begin
        r.status = ST_BAD;
      end else if (it.command == CMD_ALLOC) begin
        // Next fit: cursor to the usable end, then from block 0 up to the cursor.
        lim2 = (cursor < size) ? cursor : size;
        if (cursor < size) begin
          found = find_run(cursor, size, cnt, first);
        end
        if (!found) begin
          found = find_run(0, lim2, cnt, first);
        end
        if (found) begin
          for (int i = 0; i < cnt; i++) occupied[first + i] = 1'b1;
          cursor        = first + cnt;
          r.start_block = first[POS_W-1:0];
          r.status      = ST_OK;
        end else begin
          r.status = ST_NOSPACE;
        end
      end else begin
        r.status = ST_OK;
        if (pos + cnt > size) begin
          r.status = ST_BAD;
        end else begin
          for (int i = 0; i < cnt; i++) begin
            if (!occupied[pos + i]) r.status = ST_BAD;
          end
        end
        if (r.status == ST_OK) begin
          for (int i = 0; i < cnt; i++) occupied[pos + i] = 1'b0;
          cursor = pos;
        end
      end
      return r;
    endfunction

    function void note_request(in_item_t it);
      reply_q.push_back(predict_reply(it));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (reply_q.size() == 0) begin
        report($sformatf("ERROR: unexpected reply start_block=%0d status=%0d",
                         got.start_block, got.status));
        return;
      end
      want = reply_q.pop_front();
      if (got.start_block !== want.start_block || got.status !== want.status) begin
        report($sformatf("ERROR: reply mismatch: expected start_block=%0d status=%0d, got start_block=%0d status=%0d",
                         want.start_block, want.status, got.start_block, got.status));
      end
    endfunction

    // Picks a fully occupied range inside the usable pool, so a free of it succeeds.
    function bit pick_free_range(output int pos, output int cnt);
      int held[$];
      int size, idx, lo, hi;
      size = pool_size();
      for (int i = 0; i < size; i++) begin
        if (occupied[i]) held.push_back(i);
      end
      if (held.size() == 0) return 1'b0;
      idx = held[$urandom_range(held.size() - 1)];
      lo = idx;
      while (lo > 0 && occupied[lo-1]) lo--;
      hi = idx;
      while (hi < size - 1 && occupied[hi+1]) hi++;
      if ($urandom_range(1) == 0) begin
        pos = lo;
        cnt = hi - lo + 1;
      end else begin
        pos = $urandom_range(hi, lo);
        cnt = $urandom_range(hi - pos + 1, 1);
      end
      return 1'b1;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_write_en = 1'b0;
  logic [CNT_W-1:0]   cfg_write_data = '0;

  alloc_checker sb = new();
  int replies_seen = 0;
  int burst_left = 0;

  always #2 clk = ~clk;

  bitmap_run_allocator #(
    .TOTAL_BLOCKS(POOL_BLOCKS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  // Check every reply beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_reply(out_data);
      replies_seen++;
    end
  end

  // Receiver: changing stall modes, plus two long hold-offs that back the block up.
  initial begin : receiver
    int mode, left, holds_done, pat;
    mode = 0;
    left = 0;
    holds_done = 0;
    pat = 0;
    forever begin
      @(posedge clk);
      if (!rst && holds_done < 2 && replies_seen >= ((holds_done == 0) ? 250 : 1200)) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(2);
          left = $urandom_range(200, 20);
        end
        left--;
        pat++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(99) < 40);
          default: out_stall <= ((pat % 7) < 3);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no beat or register write happens for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          cfg_write_en) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("bitmap_run_allocator_tb: done, errors");
    $finish;
  end

  function automatic in_item_t mk(logic cmd, int cnt, int pos);
    in_item_t it;
    it.command  = cmd;
    it.count    = cnt[CNT_W-1:0];
    it.position = pos[POS_W-1:0];
    return it;
  endfunction

  // Mostly well-formed traffic: small allocations and frees of occupied ranges,
  // with some raw noise mixed in.
  function automatic in_item_t next_random_item();
    int r, pos, cnt;
    r = $urandom_range(99);
    if (r >= 45 && r < 80 && sb.pick_free_range(pos, cnt)) begin
      return mk(CMD_FREE, cnt, pos);
    end
    if (r >= 80) begin
      return mk(logic'($urandom_range(1)), $urandom_range(127), $urandom_range(63));
    end
    cnt = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
    return mk(CMD_ALLOC, cnt, $urandom_range(63));
  endfunction

  // One input beat, with bursts and gaps chosen here.
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(150, 9);
        default:       gap = $urandom_range(8, 1);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_usable(input int v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_usable(v);
  endtask

  initial begin : stimulus
    int phase_usable[11];
    int phase_items[11];
    phase_usable = '{64, 1, 127, 33, 0, 100, 7, 64, 48, 2, 64};
    phase_items  = '{300, 60, 250, 200, 40, 200, 120, 250, 150, 60, 120};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners at the reset pool size: zero counts, full pool, double free,
    // out-of-range free, oversized count.
    send(mk(CMD_ALLOC, 0, 5));
    send(mk(CMD_FREE, 0, 0));
    send(mk(CMD_ALLOC, 1, 63));
    send(mk(CMD_ALLOC, 64, 0));
    send(mk(CMD_FREE, 1, 0));
    send(mk(CMD_ALLOC, 64, 0));
    send(mk(CMD_ALLOC, 1, 0));
    send(mk(CMD_FREE, 1, 63));
    send(mk(CMD_FREE, 1, 63));
    send(mk(CMD_FREE, 5, 60));
    send(mk(CMD_ALLOC, 127, 0));
    send(mk(CMD_FREE, 63, 0));
    send(mk(CMD_ALLOC, 10, 0));
    send(mk(CMD_FREE, 127, 63));
    send(mk(CMD_FREE, 64, 0));

    // Empty pool: nothing can be allocated or freed.
    wait_drained();
    write_usable(0);
    send(mk(CMD_ALLOC, 5, 0));
    send(mk(CMD_FREE, 1, 0));

    // Register value above the pool size is clamped.
    wait_drained();
    write_usable(127);
    send(mk(CMD_ALLOC, 64, 0));
    send(mk(CMD_ALLOC, 20, 21));

    // Shrinking the pool leaves the cursor past the usable end.
    wait_drained();
    write_usable(20);
    send(mk(CMD_ALLOC, 3, 0));
    send(mk(CMD_ALLOC, 30, 0));
    send(mk(CMD_FREE, 3, 18));

    // Random phases, one pool size each.
    for (int p = 0; p < 11; p++) begin
      wait_drained();
      write_usable(phase_usable[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 3 && n == phase_items[p] / 2) wait_drained();
        send(next_random_item());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("ERROR: %0d expected replies never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("bitmap_run_allocator_tb: done, clean");
    end else begin
      $display("bitmap_run_allocator_tb: done, errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/bra_pkg.sv
rtl/core/bra_dpath.sv
rtl/core/bra_ctrl.sv
rtl/core/bitmap_run_allocator.sv
dv/bitmap_run_allocator_tb.sv
